/* src/ssa_pkg.sv */
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants of the slab slot allocator: field widths,
// register indexes and size limits.
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int HANDLE_W  = 10;
    localparam int COUNT_W   = 11;
    localparam int PAGE_W    = 5;
    localparam int SPP_W     = 7;
    localparam int LIMIT_W   = 5;
    localparam int OSIZE_W   = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    // Handle space covered by the free stack memory
    localparam int HANDLE_SPACE = 1 << HANDLE_W;

    localparam int MAX_PAGES          = 16;
    localparam int MAX_SLOTS_PER_PAGE = 64;
    localparam int MIN_OBJECT_SIZE    = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_PAGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE    = 2'd2;

    // Register reset values
    localparam logic [SPP_W-1:0]   RST_SLOTS_PER_PAGE = 7'd64;
    localparam logic [LIMIT_W-1:0] RST_PAGE_LIMIT     = 5'd16;
    localparam logic [OSIZE_W-1:0] RST_OBJECT_SIZE    = 13'd8;

    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [PAGE_W-1:0]   t_page;
    typedef logic [SPP_W-1:0]    t_spp;
    typedef logic [LIMIT_W-1:0]  t_limit;
    typedef logic [COUNT_W:0]    t_count_ext;

endpackage

/* src/ssa_in_if.sv */
// ----------------------------------------------------------------------------
// ssa_in_if
// Request channel: valid/ready handshake carrying mode and free_handle.
// ----------------------------------------------------------------------------
interface ssa_in_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [ssa_pkg::HANDLE_W-1:0] free_handle;

    modport source (output valid, output mode, output free_handle, input ready);
    modport sink   (input valid, input mode, input free_handle, output ready);
endinterface

/* src/ssa_out_if.sv */
// ----------------------------------------------------------------------------
// ssa_out_if
// Response channel: valid/ready handshake carrying the allocation result
// and the pool counters.
// ----------------------------------------------------------------------------
interface ssa_out_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [ssa_pkg::HANDLE_W-1:0] handle;
    logic [ssa_pkg::PAGE_W-1:0]   page_count;
    logic [ssa_pkg::COUNT_W-1:0]  total_slots;
    logic [ssa_pkg::COUNT_W-1:0]  used_slots;
    logic [ssa_pkg::COUNT_W-1:0]  free_slots;

    modport source (
        output valid, output ok, output handle, output page_count,
        output total_slots, output used_slots, output free_slots,
        input ready
    );
    modport sink (
        input valid, input ok, input handle, input page_count,
        input total_slots, input used_slots, input free_slots,
        output ready
    );
endinterface

/* src/slab_slot_allocator.sv */
// ----------------------------------------------------------------------------
// slab_slot_allocator
// Hands out slot handles from pages of slots through a LIFO free stack held
// in one synchronous memory; adds a page on the first request and when an allocation finds it empty.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      word
//  i_req     in   valid/ready    mode, free_handle
//  o_rsp     out  valid/ready    ok, handle, page_count, total/used/free slots
//  i_cfg_*   in   write enable   index, data (no read-back)
//
//  A free or a failed request completes from S_EXEC; an allocation passes
//  on to S_POP, since the pop reads the stack memory, whose data is registered.
//  Adding a page writes one stack entry a cycle, one per slot of the page,
//  and then re-runs the request.
//  The response register lets the next word in while a result waits; a
//  request that must deliver stalls while that register is still full.
//  Reset is synchronous; the stack memory needs no clearing pass.
//
module slab_slot_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ssa_in_if.sink                        i_req,
    ssa_out_if.source                     o_rsp,
    input  logic                          i_cfg_we,
    input  logic [ssa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ssa_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;
    localparam logic [1:0] S_POP  = 2'd3;

    // Configuration
    ssa_pkg::t_spp                   r_spp,   n_spp;
    ssa_pkg::t_limit                 r_limit, n_limit;
    logic [ssa_pkg::OSIZE_W-1:0]     r_osize, n_osize;

    // Pool state
    logic [1:0]          r_state,   n_state;
    logic                r_started, n_started;
    ssa_pkg::t_count     r_depth,   n_depth;
    ssa_pkg::t_count     r_used,    n_used;
    ssa_pkg::t_count     r_total,   n_total;
    ssa_pkg::t_page      r_pages,   n_pages;
    ssa_pkg::t_handle    r_fill_cnt, n_fill_cnt;

    // Latched request
    logic                r_mode, n_mode;
    ssa_pkg::t_handle    r_h,    n_h;

    // Response register
    logic                r_out_valid, n_out_valid;
    logic                r_o_ok,      n_o_ok;
    ssa_pkg::t_handle    r_o_handle,  n_o_handle;
    ssa_pkg::t_page      r_o_pages,   n_o_pages;
    ssa_pkg::t_count     r_o_total,   n_o_total;
    ssa_pkg::t_count     r_o_used,    n_o_used;
    ssa_pkg::t_count     r_o_free,    n_o_free;

    // Stack memory
    ssa_pkg::t_handle    r_mem [ssa_pkg::HANDLE_SPACE];
    ssa_pkg::t_handle    r_rd_data;
    logic                w_we, w_re;
    ssa_pkg::t_handle    w_waddr, w_wdata, w_raddr;

    ssa_pkg::t_spp       w_spp_eff;
    ssa_pkg::t_limit     w_limit_eff;
    logic                w_can_add;
    logic                w_out_free;
    logic                w_load;
    logic                w_ok;
    ssa_pkg::t_handle    w_handle;
    ssa_pkg::t_handle    w_fill_last;
    ssa_pkg::t_count     w_depth_m1;

    assign w_spp_eff = (int'(r_spp) > ssa_pkg::MAX_SLOTS_PER_PAGE)
                     ? ssa_pkg::t_spp'(ssa_pkg::MAX_SLOTS_PER_PAGE) : r_spp;
    assign w_limit_eff = (int'(r_limit) > ssa_pkg::MAX_PAGES)
                       ? ssa_pkg::t_limit'(ssa_pkg::MAX_PAGES) : r_limit;

    // A page fits when it has slots, the limit allows it and all its handles stay in range
    assign w_can_add = (w_spp_eff != '0) && (r_pages < w_limit_eff)
                    && ((ssa_pkg::t_count_ext'(r_total) + ssa_pkg::t_count_ext'(w_spp_eff))
                        <= ssa_pkg::t_count_ext'(ssa_pkg::HANDLE_SPACE));

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_fill_last = ssa_pkg::t_handle'(w_spp_eff) - ssa_pkg::t_handle'(1);
    assign w_depth_m1  = r_depth - ssa_pkg::t_count'(1);

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_spp       = r_spp;
        n_limit     = r_limit;
        n_osize     = r_osize;
        n_state     = r_state;
        n_started   = r_started;
        n_depth     = r_depth;
        n_used      = r_used;
        n_total     = r_total;
        n_pages     = r_pages;
        n_fill_cnt  = r_fill_cnt;
        n_mode      = r_mode;
        n_h         = r_h;
        n_out_valid = r_out_valid;
        n_o_ok      = r_o_ok;
        n_o_handle  = r_o_handle;
        n_o_pages   = r_o_pages;
        n_o_total   = r_o_total;
        n_o_used    = r_o_used;
        n_o_free    = r_o_free;
        w_we        = 1'b0;
        w_waddr     = r_fill_cnt;
        w_wdata     = ssa_pkg::t_handle'(r_total) + r_fill_cnt;
        w_re        = 1'b0;
        w_raddr     = w_depth_m1[ssa_pkg::HANDLE_W-1:0];
        w_load      = 1'b0;
        w_ok        = 1'b0;
        w_handle    = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode  = i_req.mode;
                    n_h     = i_req.free_handle;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    if (!r_started) begin
                        if (int'(r_osize) >= ssa_pkg::MIN_OBJECT_SIZE && w_can_add) begin
                            n_fill_cnt = '0;
                            n_state    = S_FILL;
                        end else begin
                            w_load  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else if (!r_mode) begin
                        if (r_depth == '0) begin
                            if (w_can_add) begin
                                n_fill_cnt = '0;
                                n_state    = S_FILL;
                            end else begin
                                w_load  = 1'b1;
                                n_state = S_IDLE;
                            end
                        end else begin
                            // pop: data comes back next cycle
                            w_re    = 1'b1;
                            n_depth = w_depth_m1;
                            n_used  = r_used + ssa_pkg::t_count'(1);
                            n_state = S_POP;
                        end
                    end else begin
                        if (r_used != '0 && ssa_pkg::t_count'(r_h) < r_total
                            && int'(r_depth) < ssa_pkg::HANDLE_SPACE) begin
                            w_we    = 1'b1;
                            w_waddr = r_depth[ssa_pkg::HANDLE_W-1:0];
                            w_wdata = r_h;
                            n_depth = r_depth + ssa_pkg::t_count'(1);
                            n_used  = r_used - ssa_pkg::t_count'(1);
                            w_ok    = 1'b1;
                        end
                        w_load  = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_FILL: begin
                // push the new page's handles in slot order from the stack bottom
                w_we = 1'b1;
                if (r_fill_cnt == w_fill_last) begin
                    n_depth   = ssa_pkg::t_count'(w_spp_eff);
                    n_total   = r_total + ssa_pkg::t_count'(w_spp_eff);
                    n_pages   = r_pages + ssa_pkg::t_page'(1);
                    n_started = 1'b1;
                    n_state   = S_EXEC;
                end else begin
                    n_fill_cnt = r_fill_cnt + ssa_pkg::t_handle'(1);
                end
            end
            S_POP: begin
                if (w_out_free) begin
                    w_load   = 1'b1;
                    w_ok     = 1'b1;
                    w_handle = r_rd_data;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
            n_o_ok      = w_ok;
            n_o_handle  = w_handle;
            n_o_pages   = n_pages;
            n_o_total   = n_total;
            n_o_used    = n_used;
            n_o_free    = n_total - n_used;
        end

        // The user must write only while idle; the block does not enforce it; a geometry change drops the pool
        if (i_cfg_we) begin
            case (i_cfg_idx)
                ssa_pkg::CFG_SLOTS_PER_PAGE,
                ssa_pkg::CFG_PAGE_LIMIT: begin
                    if (i_cfg_idx == ssa_pkg::CFG_SLOTS_PER_PAGE) begin
                        n_spp = i_cfg_data[ssa_pkg::SPP_W-1:0];
                    end else begin
                        n_limit = i_cfg_data[ssa_pkg::LIMIT_W-1:0];
                    end
                    n_started = 1'b0;
                    n_depth   = '0;
                    n_used    = '0;
                    n_total   = '0;
                    n_pages   = '0;
                end
                ssa_pkg::CFG_OBJECT_SIZE: begin
                    n_osize = i_cfg_data[ssa_pkg::OSIZE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spp       <= ssa_pkg::RST_SLOTS_PER_PAGE;
            r_limit     <= ssa_pkg::RST_PAGE_LIMIT;
            r_osize     <= ssa_pkg::RST_OBJECT_SIZE;
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_depth     <= '0;
            r_used      <= '0;
            r_total     <= '0;
            r_pages     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_spp       <= n_spp;
            r_limit     <= n_limit;
            r_osize     <= n_osize;
            r_state     <= n_state;
            r_started   <= n_started;
            r_depth     <= n_depth;
            r_used      <= n_used;
            r_total     <= n_total;
            r_pages     <= n_pages;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fill_cnt <= n_fill_cnt;
        r_mode     <= n_mode;
        r_h        <= n_h;
        r_o_ok     <= n_o_ok;
        r_o_handle <= n_o_handle;
        r_o_pages  <= n_o_pages;
        r_o_total  <= n_o_total;
        r_o_used   <= n_o_used;
        r_o_free   <= n_o_free;
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_o_ok;
    assign o_rsp.handle      = r_o_handle;
    assign o_rsp.page_count  = r_o_pages;
    assign o_rsp.total_slots = r_o_total;
    assign o_rsp.used_slots  = r_o_used;
    assign o_rsp.free_slots  = r_o_free;

`ifndef NO_ASSERTIONS
    // Every slot of the added pages is either on the stack or handed out
    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ssa_pkg::t_count_ext'(r_depth) + ssa_pkg::t_count_ext'(r_used))
            == ssa_pkg::t_count_ext'(r_total))
        else $error("stack depth plus used slots differs from total slots");

    a_page_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pages <= w_limit_eff)
        else $error("page count above the page limit");

    a_empty_before_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (r_pages == '0 && r_depth == '0 && r_used == '0))
        else $error("pool holds slots before the first page was added");

    a_pop_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_used != '0 && $past(r_state) != S_IDLE))
        else $error("pop result without a counted allocation");

    a_fill_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && $past(r_state) != S_FILL) |-> $past(r_state) == S_EXEC)
        else $error("page fill entered outside request execution");
`endif

endmodule
